FILE: src/shdc_pkg.sv
// ----------------------------------------------------------------------------
// shdc_pkg
// Shared widths and controller/datapath command and status types for the
// sparse hint decoder and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package shdc_pkg;

    localparam int BYTE_W         = 8;
    localparam int POLY_W         = 3;
    localparam int WORD_W         = 2;
    localparam int HINT_W         = 64;
    localparam int WORDS_PER_POLY = 4;
    localparam int MAP_W          = HINT_W * WORDS_PER_POLY;

    typedef struct packed {
        logic load_wr;
        logic cnt_rd;
        logic cnt_ld;
        logic j_rd;
        logic idx_use;
        logic pad_start;
        logic pad_use;
        logic word_adv;
    } t_dp_cmd;

    typedef struct packed {
        logic load_last;
        logic idx_more;
        logic pad_more;
        logic last_poly;
        logic last_word;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: src/shdc_byte_if.sv
// ----------------------------------------------------------------------------
// shdc_byte_if
// Valid/ready channel carrying one hint section byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface shdc_byte_if;

    logic                      valid;
    logic                      ready;
    logic [shdc_pkg::BYTE_W-1:0] hint_byte;

    modport source (output valid, output hint_byte, input ready);
    modport sink   (input valid, input hint_byte, output ready);

endinterface

`default_nettype wire

FILE: src/shdc_word_if.sv
// ----------------------------------------------------------------------------
// shdc_word_if
// Valid/ready channel carrying one 64-bit hint map word with its tags.
// ----------------------------------------------------------------------------
`default_nettype none

interface shdc_word_if;

    logic                        valid;
    logic                        ready;
    logic [shdc_pkg::POLY_W-1:0] poly_number;
    logic [shdc_pkg::WORD_W-1:0] word_number;
    logic [shdc_pkg::HINT_W-1:0] hint_bits;
    logic                        malformed;
    logic                        final_word;

    modport source (output valid, output poly_number, output word_number,
                    output hint_bits, output malformed, output final_word,
                    input ready);
    modport sink   (input valid, input poly_number, input word_number,
                    input hint_bits, input malformed, input final_word,
                    output ready);

endinterface

`default_nettype wire

FILE: src/shdc_ctrl.sv
// ----------------------------------------------------------------------------
// shdc_ctrl
// Sequencer: load bytes, read each count, walk its indices, check padding,
// then hand out the four map words of each polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module shdc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_out_ready,
    input  wire shdc_pkg::t_dp_status i_status,
    output shdc_pkg::t_dp_cmd         o_cmd,
    output logic                      o_in_ready,
    output logic                      o_out_valid
);
    import shdc_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CNT_RD,
        ST_CNT_LD,
        ST_IDX_CHK,
        ST_IDX_USE,
        ST_PAD_CHK,
        ST_PAD_USE,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_status.load_last) begin
                        n_state = ST_CNT_RD;
                    end
                end
            end
            ST_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = ST_CNT_LD;
            end
            ST_CNT_LD: begin
                o_cmd.cnt_ld = 1'b1;
                n_state      = ST_IDX_CHK;
            end
            ST_IDX_CHK: begin
                if (i_status.idx_more) begin
                    o_cmd.j_rd = 1'b1;
                    n_state    = ST_IDX_USE;
                end else if (i_status.last_poly) begin
                    o_cmd.pad_start = 1'b1;
                    n_state         = ST_PAD_CHK;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_IDX_USE: begin
                o_cmd.idx_use = 1'b1;
                n_state       = ST_IDX_CHK;
            end
            ST_PAD_CHK: begin
                if (i_status.pad_more) begin
                    o_cmd.j_rd = 1'b1;
                    n_state    = ST_PAD_USE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_PAD_USE: begin
                o_cmd.pad_use = 1'b1;
                n_state       = ST_PAD_CHK;
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    o_cmd.word_adv = 1'b1;
                    if (i_status.last_word) begin
                        n_state = i_status.last_poly ? ST_LOAD : ST_CNT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_EMIT);

endmodule

`default_nettype wire

FILE: src/shdc_datapath.sv
// ----------------------------------------------------------------------------
// shdc_datapath
// Section memory, count and index walkers, error flag and hint map register.
// ----------------------------------------------------------------------------
`default_nettype none

module shdc_datapath #(
    parameter int HINT_LIMIT = 55,
    parameter int POLY_COUNT = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire shdc_pkg::t_dp_cmd             i_cmd,
    input  wire logic [shdc_pkg::BYTE_W-1:0]   i_hint_byte,
    output shdc_pkg::t_dp_status               o_status,
    output logic      [shdc_pkg::POLY_W-1:0]   o_poly_number,
    output logic      [shdc_pkg::WORD_W-1:0]   o_word_number,
    output logic      [shdc_pkg::HINT_W-1:0]   o_hint_bits,
    output logic                               o_malformed,
    output logic                               o_final_word
);
    import shdc_pkg::*;

    localparam int DEPTH = HINT_LIMIT + POLY_COUNT;
    localparam int AW    = $clog2(DEPTH);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    logic [AW-1:0]     r_pos;
    logic [POLY_W-1:0] r_poly;
    logic [WORD_W-1:0] r_word;
    logic              r_err;
    logic [BYTE_W-1:0] r_start;
    logic [BYTE_W-1:0] r_cnt;
    logic [BYTE_W-1:0] r_j;
    logic [BYTE_W-1:0] r_prev;
    logic              r_first;
    logic [MAP_W-1:0]  r_map;

    logic [BYTE_W-1:0] c_limit;
    logic [BYTE_W-1:0] c_stop;
    logic [AW-1:0]     c_rd_addr;

    assign c_limit   = BYTE_W'(HINT_LIMIT);
    assign c_stop    = (r_cnt > c_limit) ? c_limit : r_cnt;
    assign c_rd_addr = i_cmd.cnt_rd ? (AW'(HINT_LIMIT) + AW'(r_poly)) : r_j[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem[r_pos] <= i_hint_byte;
        end
        if (i_cmd.cnt_rd || i_cmd.j_rd) begin
            r_rd_data <= r_mem[c_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_poly <= '0;
            r_word <= '0;
            r_err  <= 1'b0;
        end else begin
            if (i_cmd.load_wr) begin
                r_pos <= o_status.load_last ? '0 : r_pos + 1'b1;
                if (o_status.load_last) begin
                    r_poly <= '0;
                end
            end
            if (i_cmd.cnt_ld && ((r_rd_data < r_start) || (r_rd_data > c_limit))) begin
                r_err <= 1'b1;
            end
            if (i_cmd.idx_use && !r_first && (r_rd_data <= r_prev)) begin
                r_err <= 1'b1;
            end
            if (i_cmd.pad_use && (r_rd_data != '0)) begin
                r_err <= 1'b1;
            end
            if (i_cmd.word_adv) begin
                r_word <= r_word + 1'b1;
                if (o_status.last_word) begin
                    if (o_status.last_poly) begin
                        r_err <= 1'b0;
                    end else begin
                        r_poly <= r_poly + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && o_status.load_last) begin
            r_start <= '0;
        end
        if (i_cmd.word_adv && o_status.last_word) begin
            r_start <= r_cnt;
        end
        if (i_cmd.cnt_ld) begin
            r_cnt   <= r_rd_data;
            r_j     <= r_start;
            r_first <= 1'b1;
            r_map   <= '0;
        end
        if (i_cmd.idx_use) begin
            r_map[r_rd_data] <= 1'b1;
            r_prev           <= r_rd_data;
            r_first          <= 1'b0;
            r_j              <= r_j + 1'b1;
        end
        if (i_cmd.pad_start) begin
            r_j <= r_cnt;
        end
        if (i_cmd.pad_use) begin
            r_j <= r_j + 1'b1;
        end
    end

    assign o_status.load_last = (r_pos == AW'(DEPTH - 1));
    assign o_status.idx_more  = (r_j < c_stop);
    assign o_status.pad_more  = (r_j < c_limit);
    assign o_status.last_poly = (r_poly == POLY_W'(POLY_COUNT - 1));
    assign o_status.last_word = (r_word == WORD_W'(WORDS_PER_POLY - 1));

    assign o_poly_number = r_poly;
    assign o_word_number = r_word;
    assign o_hint_bits   = r_map[{r_word, 6'b000000} +: HINT_W];
    assign o_final_word  = o_status.last_poly && o_status.last_word;
    assign o_malformed   = o_final_word && r_err;

endmodule

`default_nettype wire

FILE: src/sparse_hint_decoder_checker.sv
// ----------------------------------------------------------------------------
// sparse_hint_decoder_checker
// Hint section unpack and validity check for a lattice signature.
// ----------------------------------------------------------------------------
// The block takes HINT_LIMIT + POLY_COUNT bytes, one per cycle while valid is
// held, into a single-port section memory with a registered read; no input is
// taken while a section is decoded and emitted. For each polynomial, decoding
// reads its count, walks its indices and closes the walk; after the last count
// it also checks the padding bytes, and it emits 4 * POLY_COUNT 64-bit output
// words in all, four per polynomial. Each walk step pairs a check state, which
// issues the registered memory read, with a use state, which consumes its
// data.
// malformed is reported on the final word only.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_hint_decoder_checker #(
    parameter int HINT_LIMIT = 55,
    parameter int POLY_COUNT = 6
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    shdc_byte_if.sink  i_hint,
    shdc_word_if.source o_word
);
    import shdc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    shdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_hint.valid),
        .i_out_ready (o_word.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (i_hint.ready),
        .o_out_valid (o_word.valid)
    );

    shdc_datapath #(
        .HINT_LIMIT (HINT_LIMIT),
        .POLY_COUNT (POLY_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_hint_byte   (i_hint.hint_byte),
        .o_status      (status),
        .o_poly_number (o_word.poly_number),
        .o_word_number (o_word.word_number),
        .o_hint_bits   (o_word.hint_bits),
        .o_malformed   (o_word.malformed),
        .o_final_word  (o_word.final_word)
    );

endmodule

`default_nettype wire

FILE: src/shdc_checker.sv
// ----------------------------------------------------------------------------
// shdc_checker
// Port-level checks on load/emit sequencing of the hint decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module shdc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [shdc_pkg::WORD_W-1:0] i_word_number,
    input wire logic [shdc_pkg::HINT_W-1:0] i_hint_bits,
    input wire logic                        i_malformed,
    input wire logic                        i_final_word
);
    import shdc_pkg::*;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken while words are emitted");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_hint_bits)))
        else $error("stalled word changed");

    a_word_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && (i_word_number != WORD_W'(WORDS_PER_POLY - 1)))
        |=> (i_out_valid && (i_word_number == $past(i_word_number) + 1'b1)))
        else $error("words of a polynomial not back to back");

    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_final_word) |=> (i_in_ready && !i_out_valid))
        else $error("no return to loading after final word");

    a_flag_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_malformed) |-> i_final_word)
        else $error("malformed flag on non-final word");

endmodule

bind sparse_hint_decoder_checker shdc_checker u_shdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_hint.ready),
    .i_out_valid   (o_word.valid),
    .i_out_ready   (o_word.ready),
    .i_word_number (o_word.word_number),
    .i_hint_bits   (o_word.hint_bits),
    .i_malformed   (o_word.malformed),
    .i_final_word  (o_word.final_word)
);

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the sparse hint decoder and checker against a behavioral predictor.
// Whole hint sections are sent one byte per transfer: a well formed section with
// a full index list, then sections with an oversized count (which also pulls
// later counts below the previous one), unordered indices and nonzero
// padding. Both channels idle at random. Every hint map word is compared
// field by field with the predicted one.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import shdc_pkg::*;

    localparam int HINT_LIMIT    = 55;
    localparam int POLY_COUNT    = 6;
    localparam int SECTION_LEN   = HINT_LIMIT + POLY_COUNT;
    localparam int DRAIN_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [POLY_W-1:0] poly_number;
        logic [WORD_W-1:0] word_number;
        logic [HINT_W-1:0] hint_bits;
        logic              malformed;
        logic              final_word;
    } t_hint_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    shdc_byte_if hint_if ();
    shdc_word_if word_if ();

    sparse_hint_decoder_checker #(
        .HINT_LIMIT (HINT_LIMIT),
        .POLY_COUNT (POLY_COUNT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hint  (hint_if),
        .o_word  (word_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [BYTE_W-1:0] section_store [SECTION_LEN];
    int                bytes_taken;
    logic              section_bad;
    t_hint_word        expected_words [$];

    // stimulus plan
    logic [BYTE_W-1:0] section_plan [SECTION_LEN];
    int                plan_counts [POLY_COUNT];
    bit                send_quiet;
    bit                recv_quiet;

    int                failures;
    int                ready_hold;
    int                cycle_count;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int idle_cycles(input bit quiet);
        return quiet ? 0 : $urandom_range(10, 0);
    endfunction

    task automatic decode_section();
        logic [HINT_W-1:0] hint_map [POLY_COUNT][WORDS_PER_POLY];
        logic [BYTE_W-1:0] idx;
        int                start;
        int                cnt;
        int                stop;
        t_hint_word        w;
        start = 0;
        for (int p = 0; p < POLY_COUNT; p++)
            for (int k = 0; k < WORDS_PER_POLY; k++)
                hint_map[p][k] = '0;
        for (int p = 0; p < POLY_COUNT; p++) begin
            cnt  = section_store[HINT_LIMIT + p];
            stop = (cnt > HINT_LIMIT) ? HINT_LIMIT : cnt;
            if (cnt < start || cnt > HINT_LIMIT)
                section_bad = 1'b1;
            for (int j = start; j < stop; j++) begin
                idx = section_store[j];
                if (j > start && idx <= section_store[j-1])
                    section_bad = 1'b1;
                hint_map[p][idx[7:6]][idx[5:0]] = 1'b1;
            end
            start = cnt;
        end
        for (int j = start; j < HINT_LIMIT; j++)
            if (section_store[j] != '0)
                section_bad = 1'b1;
        for (int p = 0; p < POLY_COUNT; p++) begin
            for (int k = 0; k < WORDS_PER_POLY; k++) begin
                w.poly_number = p[POLY_W-1:0];
                w.word_number = k[WORD_W-1:0];
                w.hint_bits   = hint_map[p][k];
                w.final_word  = (p == POLY_COUNT - 1) && (k == WORDS_PER_POLY - 1);
                w.malformed   = w.final_word && section_bad;
                expected_words.push_back(w);
            end
        end
        bytes_taken = 0;
        section_bad = 1'b0;
    endtask

    task automatic take_hint_byte(input logic [BYTE_W-1:0] b);
        if (bytes_taken >= SECTION_LEN)
            bytes_taken = 0;
        section_store[bytes_taken] = b;
        bytes_taken++;
        if (bytes_taken == SECTION_LEN)
            decode_section();
    endtask

    task automatic send_hint_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = idle_cycles(send_quiet);
        if (gap > 0) begin
            hint_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        hint_if.valid     <= 1'b1;
        hint_if.hint_byte <= b;
        @(posedge i_clk);
        while (!hint_if.ready) @(posedge i_clk);
        take_hint_byte(b);
    endtask

    task automatic send_section();
        send_quiet = ($urandom_range(3, 0) == 0);
        recv_quiet = ($urandom_range(3, 0) == 0);
        for (int i = 0; i < SECTION_LEN; i++)
            send_hint_byte(section_plan[i]);
    endtask

    // n distinct indices in increasing order; with_ends forces 0 and 255 in
    task automatic fill_poly_indices(input int first, input int n, input bit with_ends);
        logic [255:0] chosen;
        int           picked;
        int           v;
        int           pos;
        chosen = '0;
        picked = 0;
        if (with_ends && n >= 2) begin
            chosen[0]   = 1'b1;
            chosen[255] = 1'b1;
            picked      = 2;
        end
        while (picked < n) begin
            v = $urandom_range(255, 0);
            if (!chosen[v]) begin
                chosen[v] = 1'b1;
                picked++;
            end
        end
        pos = first;
        for (int k = 0; k < 256; k++) begin
            if (chosen[k]) begin
                section_plan[pos] = k[BYTE_W-1:0];
                pos++;
            end
        end
    endtask

    task automatic build_section(input bit with_ends);
        int prev;
        prev = 0;
        for (int i = 0; i < SECTION_LEN; i++)
            section_plan[i] = '0;
        for (int p = 0; p < POLY_COUNT; p++) begin
            fill_poly_indices(prev, plan_counts[p] - prev, with_ends && p == 0);
            section_plan[HINT_LIMIT + p] = plan_counts[p][BYTE_W-1:0];
            prev = plan_counts[p];
        end
    endtask

    task automatic check_field(input string name, input logic [HINT_W-1:0] exp_val,
                               input logic [HINT_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            failures++;
        end
    endtask

    task automatic check_hint_word();
        t_hint_word w;
        if (expected_words.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, actual poly %0d word %0d",
                     $time, word_if.poly_number, word_if.word_number);
            failures++;
        end else begin
            w = expected_words.pop_front();
            check_field("poly_number", HINT_W'(w.poly_number),
                        HINT_W'(word_if.poly_number));
            check_field("word_number", HINT_W'(w.word_number),
                        HINT_W'(word_if.word_number));
            check_field("hint_bits",   w.hint_bits,   word_if.hint_bits);
            check_field("malformed",   HINT_W'(w.malformed),
                        HINT_W'(word_if.malformed));
            check_field("final_word",  HINT_W'(w.final_word),
                        HINT_W'(word_if.final_word));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_if.ready <= 1'b0;
            ready_hold = 0;
        end else begin
            if (word_if.valid && word_if.ready) begin
                check_hint_word();
                ready_hold = idle_cycles(recv_quiet);
            end else if (ready_hold > 0) begin
                ready_hold--;
            end
            word_if.ready <= (ready_hold == 0);
        end
    end

    task automatic test_full_section();
        plan_counts = '{9, 18, 27, 36, 45, 55};
        build_section(1'b1);
        send_section();
    endtask

    task automatic test_count_too_large();
        plan_counts = '{10, 20, 30, 40, 50, 55};
        build_section(1'b0);
        section_plan[HINT_LIMIT + 2] = 8'hFF;
        send_section();
    endtask

    task automatic test_unordered_indices();
        logic [BYTE_W-1:0] held;
        plan_counts = '{10, 20, 30, 40, 50, 55};
        build_section(1'b0);
        section_plan[11] = section_plan[10];
        held             = section_plan[41];
        section_plan[41] = section_plan[42];
        section_plan[42] = held;
        send_section();
    endtask

    task automatic test_nonzero_padding();
        plan_counts = '{5, 10, 15, 20, 25, 30};
        build_section(1'b0);
        section_plan[30]             = 8'h01;
        section_plan[HINT_LIMIT - 1] = 8'h80;
        send_section();
    endtask

    initial begin
        failures    = 0;
        bytes_taken = 0;
        section_bad = 1'b0;
        cycle_count = 0;
        send_quiet  = 1'b0;
        recv_quiet  = 1'b0;
        for (int i = 0; i < SECTION_LEN; i++)
            section_store[i] = '0;
        i_rst_n           <= 1'b0;
        hint_if.valid     <= 1'b0;
        hint_if.hint_byte <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_section();
        test_count_too_large();
        test_unordered_indices();
        test_nonzero_padding();

        hint_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
